[design/srsa_pkg.sv]
// Package for the read statistics accumulator.
// Field widths, op/status/table codes, controller state and command/status structs.
// No dependencies.
package srsa_pkg;

  localparam int DEF_MAX_READ_LEN = 1024;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int LEN_W      = 11;
  localparam int QAVG_W     = 16;
  localparam int BCNT_W     = 11;
  localparam int CHAR_W     = 8;
  localparam int BQ_W       = 8;
  localparam int IDX_W      = 11;
  localparam int TAB_W      = 4;
  localparam int DATA_W     = 48;
  localparam int QSUM_W     = 40;
  localparam int NLET       = 5;
  localparam int QBINS      = 256;
  localparam int GCBINS     = 101;
  localparam int PCT_FULL   = 100;
  localparam int GC_W       = 7;
  localparam int QB_W       = 8;
  localparam int REM_W      = 18;
  localparam int DCNT_W     = 3;
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;
  localparam int NSCALAR    = 10;

  typedef enum logic [1:0] {
    OP_SUMMARY = 2'd0,
    OP_BASE    = 2'd1,
    OP_READOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_ZERO_LEN = 2'd2;

  localparam logic [TAB_W-1:0] TAB_LEN      = 4'd0;
  localparam logic [TAB_W-1:0] TAB_QUAL     = 4'd1;
  localparam logic [TAB_W-1:0] TAB_GC       = 4'd2;
  localparam logic [TAB_W-1:0] TAB_POS_CNT  = 4'd3;
  localparam logic [TAB_W-1:0] TAB_POS_QSUM = 4'd4;
  localparam logic [TAB_W-1:0] TAB_POS_A    = 4'd5;
  localparam logic [TAB_W-1:0] TAB_POS_C    = 4'd6;
  localparam logic [TAB_W-1:0] TAB_POS_T    = 4'd7;
  localparam logic [TAB_W-1:0] TAB_POS_G    = 4'd8;
  localparam logic [TAB_W-1:0] TAB_POS_N    = 4'd9;
  localparam logic [TAB_W-1:0] TAB_SCALAR   = 4'd10;

  localparam logic [IDX_W-1:0] SC_READ_COUNT = 11'd0;
  localparam logic [IDX_W-1:0] SC_SHORTEST   = 11'd1;
  localparam logic [IDX_W-1:0] SC_LONGEST    = 11'd2;
  localparam logic [IDX_W-1:0] SC_TOT_LEN    = 11'd3;
  localparam logic [IDX_W-1:0] SC_TOT_QUAL   = 11'd4;
  localparam logic [IDX_W-1:0] SC_TOT_A      = 11'd5;
  localparam logic [IDX_W-1:0] SC_TOT_C      = 11'd6;
  localparam logic [IDX_W-1:0] SC_TOT_T      = 11'd7;
  localparam logic [IDX_W-1:0] SC_TOT_G      = 11'd8;
  localparam logic [IDX_W-1:0] SC_TOT_N      = 11'd9;

  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;
  localparam logic [CHAR_W-1:0] CH_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4E;

  localparam logic [2:0] LET_A = 3'd0;
  localparam logic [2:0] LET_C = 3'd1;
  localparam logic [2:0] LET_T = 3'd2;
  localparam logic [2:0] LET_G = 3'd3;
  localparam logic [2:0] LET_N = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_WR,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_step;
    logic wr;
    logic out_load;
    logic out_hold;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic in_summary;
    logic out_busy;
  } sts_t;

  // {hit, letter index}
  function automatic logic [3:0] letter_code(input logic [CHAR_W-1:0] c);
    logic [3:0] r;
    begin
      unique case (c)
        CH_A:    r = {1'b1, LET_A};
        CH_C:    r = {1'b1, LET_C};
        CH_T:    r = {1'b1, LET_T};
        CH_G:    r = {1'b1, LET_G};
        CH_N:    r = {1'b1, LET_N};
        default: r = 4'd0;
      endcase
      return r;
    end
  endfunction

endpackage

[design/srsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/srsa_ctrl.sv]
// Controller state machine for the read statistics accumulator.
// Depends on srsa_pkg; drives commands to srsa_dp.
module srsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  srsa_pkg::sts_t sts,
  output srsa_pkg::cmd_t cmd
);
  import srsa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) state_nxt = sts.in_summary ? S_DIV : S_RD;
      end
      S_DIV:   if (sts.div_done) state_nxt = S_RD;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = sts.out_busy ? S_HOLD : S_IDLE;
      S_HOLD:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_RD:    ;
      S_WR: begin
        cmd.wr       = 1'b1;
        cmd.out_load = !sts.out_busy;
      end
      S_HOLD: begin
        cmd.out_load = !sts.out_busy;
        cmd.out_hold = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("item accepted while another is in flight");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(state_r) == S_RD)
    else $error("memory write without preceding read");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten");
`endif

endmodule

[design/srsa_dp.sv]
// Datapath: histogram and per-position memories, scalar totals, GC divider, result register.
// Depends on srsa_pkg and srsa_ram; controlled by srsa_ctrl.
module srsa_dp #(
  parameter int MAX_READ_LEN = srsa_pkg::DEF_MAX_READ_LEN,
  parameter int COUNT_BITS   = srsa_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [srsa_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [srsa_pkg::IN_USER_W-1:0]      in_tuser,
  input  srsa_pkg::cmd_t                      cmd,
  output srsa_pkg::sts_t                      sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [srsa_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [srsa_pkg::OUT_USER_W-1:0]     out_tuser
);
  import srsa_pkg::*;

  localparam int LHD   = MAX_READ_LEN + 1;
  localparam int LHA   = $clog2(LHD);
  localparam int PD    = MAX_READ_LEN;
  localparam int PA    = $clog2(PD);
  localparam int PBD   = MAX_READ_LEN * NLET;
  localparam int PBA   = $clog2(PBD);
  localparam int QHA   = $clog2(QBINS);
  localparam int GCA   = $clog2(GCBINS);
  localparam int CLR_D = (PBD > QBINS) ? PBD : QBINS;
  localparam int CLR_W = $clog2(CLR_D);
  localparam logic [16:0] MAXL = 17'(MAX_READ_LEN);

  // item registers
  op_t                op_r;
  logic [LEN_W-1:0]   len_r;
  logic [QAVG_W-1:0]  q_r;
  logic [BCNT_W-1:0]  cnt_r [NLET];
  logic [CHAR_W-1:0]  char_r;
  logic [BQ_W-1:0]    bq_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TAB_W-1:0]   tab_r;

  // scalars
  logic [COUNT_BITS-1:0] read_count_r;
  logic [LEN_W-1:0]      shortest_r, longest_r;
  logic [DATA_W-1:0]     tot_len_r, tot_q_r;
  logic [DATA_W-1:0]     btot_r [NLET];

  // divider
  logic [REM_W-1:0]  rem_r;
  logic [GC_W-1:0]   quo_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              gc_big_r;

  logic [CLR_W-1:0]  clr_cnt_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, res_data_r;
  status_t           out_status_r, res_status_r;

  // input unpack
  logic [BCNT_W-1:0] in_cnt [NLET];
  logic [BCNT_W:0]   in_gcsum;
  logic [REM_W-1:0]  in_num;
  op_t               in_op;

  always_comb begin
    in_op = op_t'(in_tuser[1:0]);
    for (int i = 0; i < NLET; i++) begin
      in_cnt[i] = in_tdata[27 + i*BCNT_W +: BCNT_W];
    end
    in_gcsum = {1'b0, in_cnt[3]} + {1'b0, in_cnt[1]};
    in_num   = {in_gcsum, 6'd0} + {1'b0, in_gcsum, 5'd0} + {4'd0, in_gcsum, 2'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      len_r  <= in_tdata[10:0];
      q_r    <= in_tdata[26:11];
      for (int i = 0; i < NLET; i++) begin
        cnt_r[i] <= in_cnt[i];
      end
      char_r <= in_tdata[89:82];
      bq_r   <= in_tdata[97:90];
      idx_r  <= in_tdata[108:98];
      tab_r  <= in_tuser[5:2];
    end
  end

  // GC percent: restoring division, one quotient bit a cycle
  logic [REM_W-1:0] trial;
  assign trial = {7'd0, len_r} << div_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r     <= in_num;
      quo_r     <= '0;
      div_cnt_r <= 3'(GC_W - 1);
      gc_big_r  <= in_gcsum >= {1'b0, in_tdata[10:0]};
    end else if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        quo_r <= quo_r | (7'd1 << div_cnt_r);
      end
      div_cnt_r <= div_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // derived item values
  logic              len_ok, pos_ok, len_zero, is_rd;
  logic [3:0]        let_c;
  logic [16:0]       qround;
  logic [QHA-1:0]    qbin;
  logic [GCA-1:0]    gc;
  logic [13:0]       pb_sum;
  logic [2:0]        pb_let;
  logic [TAB_W-1:0]  tab_off;

  always_comb begin
    is_rd    = (op_r == OP_READOUT);
    len_ok   = {6'd0, len_r} <= MAXL;
    pos_ok   = {6'd0, idx_r} < MAXL;
    len_zero = (len_r == '0);
    let_c    = letter_code(char_r);
    qround   = {1'b0, q_r} + 17'd128;
    qbin     = qround[16] ? {QHA{1'b1}} : qround[15:8];
    gc       = gc_big_r ? GCA'(PCT_FULL) : quo_r;
    tab_off  = tab_r - TAB_POS_A;
    pb_let   = is_rd ? tab_off[2:0] : let_c[2:0];
    pb_sum   = {1'b0, idx_r, 2'd0} + {3'd0, idx_r} + {11'd0, pb_let};
  end

  // memories
  logic [COUNT_BITS-1:0] lh_rd, qh_rd, gh_rd, pc_rd, pb_rd;
  logic [QSUM_W-1:0]     pq_rd;
  logic [COUNT_BITS-1:0] lh_wd, qh_wd, gh_wd, pc_wd, pb_wd;
  logic [QSUM_W-1:0]     pq_wd;
  logic                  lh_we, qh_we, gh_we, pc_we, pq_we, pb_we;
  logic [LHA-1:0]        lh_ra, lh_wa;
  logic [QHA-1:0]        qh_ra, qh_wa;
  logic [GCA-1:0]        gh_ra, gh_wa;
  logic [PA-1:0]         p_ra, p_wa;
  logic [PBA-1:0]        pb_ra, pb_wa;
  logic [QSUM_W:0]       pq_add;
  logic                  w_sum, w_base;

  always_comb begin
    lh_ra  = is_rd ? LHA'(idx_r) : LHA'(len_r);
    qh_ra  = is_rd ? idx_r[QHA-1:0] : qbin;
    gh_ra  = is_rd ? idx_r[GCA-1:0] : gc;
    p_ra   = PA'(idx_r);
    pb_ra  = PBA'(pb_sum);
    w_sum  = cmd.wr && (op_r == OP_SUMMARY);
    w_base = cmd.wr && (op_r == OP_BASE) && pos_ok;
    pq_add = {1'b0, pq_rd} + {{(QSUM_W + 1 - BQ_W){1'b0}}, bq_r};
    if (cmd.clear) begin
      lh_we = 32'(clr_cnt_r) < LHD;
      qh_we = 32'(clr_cnt_r) < QBINS;
      gh_we = 32'(clr_cnt_r) < GCBINS;
      pc_we = 32'(clr_cnt_r) < PD;
      pq_we = 32'(clr_cnt_r) < PD;
      pb_we = 32'(clr_cnt_r) < PBD;
      lh_wa = LHA'(clr_cnt_r);
      qh_wa = QHA'(clr_cnt_r);
      gh_wa = GCA'(clr_cnt_r);
      p_wa  = PA'(clr_cnt_r);
      pb_wa = PBA'(clr_cnt_r);
      lh_wd = '0;
      qh_wd = '0;
      gh_wd = '0;
      pc_wd = '0;
      pq_wd = '0;
      pb_wd = '0;
    end else begin
      lh_we = w_sum && len_ok;
      qh_we = w_sum;
      gh_we = w_sum && !len_zero;
      pc_we = w_base;
      pq_we = w_base;
      pb_we = w_base && let_c[3];
      lh_wa = lh_ra;
      qh_wa = qh_ra;
      gh_wa = gh_ra;
      p_wa  = p_ra;
      pb_wa = pb_ra;
      lh_wd = (&lh_rd) ? lh_rd : lh_rd + 1'b1;
      qh_wd = (&qh_rd) ? qh_rd : qh_rd + 1'b1;
      gh_wd = (&gh_rd) ? gh_rd : gh_rd + 1'b1;
      pc_wd = (&pc_rd) ? pc_rd : pc_rd + 1'b1;
      pb_wd = (&pb_rd) ? pb_rd : pb_rd + 1'b1;
      pq_wd = pq_add[QSUM_W] ? {QSUM_W{1'b1}} : pq_add[QSUM_W-1:0];
    end
  end

  srsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(LHD)) u_len_hist (
    .clk(clk), .we(lh_we), .waddr(lh_wa), .wdata(lh_wd), .raddr(lh_ra), .rdata(lh_rd)
  );
  srsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(QBINS)) u_qual_hist (
    .clk(clk), .we(qh_we), .waddr(qh_wa), .wdata(qh_wd), .raddr(qh_ra), .rdata(qh_rd)
  );
  srsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(GCBINS)) u_gc_hist (
    .clk(clk), .we(gh_we), .waddr(gh_wa), .wdata(gh_wd), .raddr(gh_ra), .rdata(gh_rd)
  );
  srsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(PD)) u_pos_cnt (
    .clk(clk), .we(pc_we), .waddr(p_wa), .wdata(pc_wd), .raddr(p_ra), .rdata(pc_rd)
  );
  srsa_ram #(.WIDTH(QSUM_W), .DEPTH(PD)) u_pos_qsum (
    .clk(clk), .we(pq_we), .waddr(p_wa), .wdata(pq_wd), .raddr(p_ra), .rdata(pq_rd)
  );
  srsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(PBD)) u_pos_base (
    .clk(clk), .we(pb_we), .waddr(pb_wa), .wdata(pb_wd), .raddr(pb_ra), .rdata(pb_rd)
  );

  // scalar totals
  logic [DATA_W:0] tl_add, tq_add;
  logic [DATA_W:0] bt_add [NLET];

  always_comb begin
    tl_add = {1'b0, tot_len_r} + {{(DATA_W + 1 - LEN_W){1'b0}}, len_r};
    tq_add = {1'b0, tot_q_r} + {{(DATA_W + 1 - QAVG_W){1'b0}}, q_r};
    for (int i = 0; i < NLET; i++) begin
      bt_add[i] = {1'b0, btot_r[i]} + {{(DATA_W + 1 - BCNT_W){1'b0}}, cnt_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_count_r <= '0;
      shortest_r   <= '1;
      longest_r    <= '0;
      tot_len_r    <= '0;
      tot_q_r      <= '0;
      for (int i = 0; i < NLET; i++) begin
        btot_r[i] <= '0;
      end
    end else if (w_sum) begin
      if (!(&read_count_r)) read_count_r <= read_count_r + 1'b1;
      if (len_r < shortest_r) shortest_r <= len_r;
      if (len_r > longest_r) longest_r <= len_r;
      tot_len_r <= tl_add[DATA_W] ? {DATA_W{1'b1}} : tl_add[DATA_W-1:0];
      tot_q_r   <= tq_add[DATA_W] ? {DATA_W{1'b1}} : tq_add[DATA_W-1:0];
      for (int i = 0; i < NLET; i++) begin
        btot_r[i] <= bt_add[i][DATA_W] ? {DATA_W{1'b1}} : bt_add[i][DATA_W-1:0];
      end
    end
  end

  // read-out and result
  logic [DATA_W-1:0] ro_data, sc_data, res_data;
  status_t           ro_status, res_status;
  logic              sc_ok;

  always_comb begin
    sc_ok = 1'b1;
    unique case (idx_r)
      SC_READ_COUNT: sc_data = DATA_W'(read_count_r);
      SC_SHORTEST:   sc_data = DATA_W'(shortest_r);
      SC_LONGEST:    sc_data = DATA_W'(longest_r);
      SC_TOT_LEN:    sc_data = tot_len_r;
      SC_TOT_QUAL:   sc_data = tot_q_r;
      SC_TOT_A:      sc_data = btot_r[0];
      SC_TOT_C:      sc_data = btot_r[1];
      SC_TOT_T:      sc_data = btot_r[2];
      SC_TOT_G:      sc_data = btot_r[3];
      SC_TOT_N:      sc_data = btot_r[4];
      default: begin
        sc_data = '0;
        sc_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    ro_data   = '0;
    ro_status = ST_OK;
    unique case (tab_r)
      TAB_LEN: begin
        if ({6'd0, idx_r} <= MAXL) ro_data = DATA_W'(lh_rd);
        else ro_status = ST_RANGE;
      end
      TAB_QUAL: begin
        if (32'(idx_r) < QBINS) ro_data = DATA_W'(qh_rd);
        else ro_status = ST_RANGE;
      end
      TAB_GC: begin
        if (32'(idx_r) < GCBINS) ro_data = DATA_W'(gh_rd);
        else ro_status = ST_RANGE;
      end
      TAB_POS_CNT: begin
        if (pos_ok) ro_data = DATA_W'(pc_rd);
        else ro_status = ST_RANGE;
      end
      TAB_POS_QSUM: begin
        if (pos_ok) ro_data = DATA_W'(pq_rd);
        else ro_status = ST_RANGE;
      end
      TAB_POS_A, TAB_POS_C, TAB_POS_T, TAB_POS_G, TAB_POS_N: begin
        if (pos_ok) ro_data = DATA_W'(pb_rd);
        else ro_status = ST_RANGE;
      end
      TAB_SCALAR: begin
        ro_data   = sc_data;
        ro_status = sc_ok ? ST_OK : ST_RANGE;
      end
      default: ro_status = ST_RANGE;
    endcase
  end

  always_comb begin
    res_data   = '0;
    res_status = ST_OK;
    unique case (op_r)
      OP_SUMMARY: res_status = len_zero ? ST_ZERO_LEN : (len_ok ? ST_OK : ST_RANGE);
      OP_BASE:    res_status = pos_ok ? ST_OK : ST_RANGE;
      OP_READOUT: begin
        res_data   = ro_data;
        res_status = ro_status;
      end
      OP_NONE:    ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      res_data_r   <= res_data;
      res_status_r <= res_status;
    end
    if (cmd.out_load) begin
      out_data_r   <= cmd.out_hold ? res_data_r : res_data;
      out_status_r <= cmd.out_hold ? res_status_r : res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.clr_done   = 32'(clr_cnt_r) == CLR_D - 1;
    sts.div_done   = div_cnt_r == '0;
    sts.in_summary = in_op == OP_SUMMARY;
    sts.out_busy   = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (read_count_r != '0) |-> shortest_r <= longest_r)
    else $error("shortest length above longest length");
  a_gc_range: assert property (@(posedge clk) disable iff (!rst_n)
    gh_we && !cmd.clear |-> 32'(gc) <= PCT_FULL)
    else $error("GC bin beyond 100 percent");
`endif

endmodule

[design/sequencing_read_stats_accumulator.sv]
// Top level of the sequencing read statistics accumulator.
// Depends on srsa_pkg, srsa_ctrl, srsa_dp (and srsa_ram through srsa_dp).
//
// Usage:
//  in_*  : one transaction per item. in_tuser selects the op (summary, base, read-out)
//          and the read-out table; in_tdata carries the read summary, base and index.
//  out_* : exactly one transaction per input item: read_data in out_tdata and the
//          status code in out_tuser (ok, index out of range, zero-length read).
//  Each item passes from acceptance through the read and write states to the output
//  register; summary items first pass the divide state, where their GC percentage
//  comes from a 7-step restoring divider. Summary and in-range base items do one
//  read-modify-write of the memories; read-out items only read them. One item is in
//  flight at a time; a new item is accepted while the previous result still waits
//  in the output register.
//  After reset the memories are swept to zero, one entry a cycle over
//  max(5*MAX_READ_LEN, 256) entries (5120 at the default); in_tready stays low meanwhile.
//  When the receiver stalls the result holds in the output register and at most
//  one further result is parked; the block then stops accepting items.
module sequencing_read_stats_accumulator #(
  parameter int MAX_READ_LEN = srsa_pkg::DEF_MAX_READ_LEN,
  parameter int COUNT_BITS   = srsa_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // rlen, quality_avg_q8, count_a, count_c, count_t, count_g, count_n,
  // base_char, base_quality, index, zero pad
  input  logic [srsa_pkg::IN_DATA_W-1:0]  in_tdata,
  // op, table_select
  input  logic [srsa_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data
  output logic [srsa_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [srsa_pkg::OUT_USER_W-1:0] out_tuser
);
  import srsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srsa_dp #(
    .MAX_READ_LEN (MAX_READ_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[sim/testbench.sv]
// Testbench for sequencing_read_stats_accumulator: directed and random summary, base and
// read-out transactions, checked against a predictor of the statistics store.
// Depends on srsa_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;
  import srsa_pkg::*;

  localparam int MAXLEN  = DEF_MAX_READ_LEN;
  localparam longint CNT_TOP = (64'd1 << DEF_COUNT_BITS) - 1;
  localparam longint TOP48 = 64'hFFFF_FFFF_FFFF;
  localparam longint TOP40 = 64'hFF_FFFF_FFFF;
  localparam int WDOG_LIMIT = 40000;
  localparam int QUIET_TAIL = 500;

  typedef struct packed {
    op_t               op;
    logic [TAB_W-1:0]  tsel;
    logic [LEN_W-1:0]  rlen;
    logic [QAVG_W-1:0] qavg;
    logic [BCNT_W-1:0] ca, cc, ct, cg, cn;
    logic [CHAR_W-1:0] bchar;
    logic [BQ_W-1:0]   bqual;
    logic [IDX_W-1:0]  idx;
  } stat_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    status_t           st;
  } stat_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  always #1 clk = ~clk;

  sequencing_read_stats_accumulator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state
  longint unsigned n_reads, len_min, len_max, len_sum, qual_sum;
  longint unsigned let_sum [NLET];
  longint unsigned len_hist [MAXLEN+1];
  longint unsigned qual_hist [QBINS];
  longint unsigned gc_hist [GCBINS];
  longint unsigned pos_cnt [MAXLEN];
  longint unsigned pos_qsum [MAXLEN];
  longint unsigned pos_let [MAXLEN*NLET];

  stat_item_t   pending_items [$];
  stat_result_t expected_results [$];
  bit failed = 0;
  bit stim_done = 0;
  int wdog = 0;

  function automatic longint unsigned sat_inc(longint unsigned acc, longint unsigned inc,
                                              longint unsigned top);
    if (acc >= top || inc > top - acc) return top;
    return acc + inc;
  endfunction

  function automatic int letter_index(logic [CHAR_W-1:0] c);
    case (c)
      CH_A: return LET_A;
      CH_C: return LET_C;
      CH_T: return LET_T;
      CH_G: return LET_G;
      CH_N: return LET_N;
      default: return -1;
    endcase
  endfunction

  task automatic clear_stats();
    n_reads = 0; len_min = 2047; len_max = 0; len_sum = 0; qual_sum = 0;
    foreach (let_sum[i]) let_sum[i] = 0;
    foreach (len_hist[i]) len_hist[i] = 0;
    foreach (qual_hist[i]) qual_hist[i] = 0;
    foreach (gc_hist[i]) gc_hist[i] = 0;
    foreach (pos_cnt[i]) pos_cnt[i] = 0;
    foreach (pos_qsum[i]) pos_qsum[i] = 0;
    foreach (pos_let[i]) pos_let[i] = 0;
  endtask

  task automatic accumulate_stats(input stat_item_t it, output stat_result_t r);
    longint unsigned len, qb, gc, ix;
    longint unsigned cnt [NLET];
    int l;
    r = '0;
    len = it.rlen;
    ix = it.idx;
    case (it.op)
      OP_SUMMARY: begin
        cnt[0] = it.ca; cnt[1] = it.cc; cnt[2] = it.ct; cnt[3] = it.cg; cnt[4] = it.cn;
        n_reads = sat_inc(n_reads, 1, CNT_TOP);
        len_sum = sat_inc(len_sum, len, TOP48);
        if (len < len_min) len_min = len;
        if (len > len_max) len_max = len;
        qual_sum = sat_inc(qual_sum, it.qavg, TOP48);
        for (int i = 0; i < NLET; i++) let_sum[i] = sat_inc(let_sum[i], cnt[i], TOP48);
        if (len <= MAXLEN) len_hist[len] = sat_inc(len_hist[len], 1, CNT_TOP);
        else r.st = ST_RANGE;
        qb = (longint'(it.qavg) + 128) >> 8;
        if (qb > QBINS - 1) qb = QBINS - 1;
        qual_hist[qb] = sat_inc(qual_hist[qb], 1, CNT_TOP);
        if (len == 0) r.st = ST_ZERO_LEN;
        else begin
          gc = (PCT_FULL * (cnt[3] + cnt[1])) / len;
          if (gc > PCT_FULL) gc = PCT_FULL;
          gc_hist[gc] = sat_inc(gc_hist[gc], 1, CNT_TOP);
        end
      end
      OP_BASE: begin
        if (ix >= MAXLEN) r.st = ST_RANGE;
        else begin
          pos_cnt[ix] = sat_inc(pos_cnt[ix], 1, CNT_TOP);
          pos_qsum[ix] = sat_inc(pos_qsum[ix], it.bqual, TOP40);
          l = letter_index(it.bchar);
          if (l >= 0) pos_let[ix*NLET+l] = sat_inc(pos_let[ix*NLET+l], 1, CNT_TOP);
        end
      end
      OP_READOUT: begin
        r.st = ST_RANGE;
        if (it.tsel == TAB_LEN) begin
          if (ix <= MAXLEN) begin r.rdata = DATA_W'(len_hist[ix]); r.st = ST_OK; end
        end else if (it.tsel == TAB_QUAL) begin
          if (ix < QBINS) begin r.rdata = DATA_W'(qual_hist[ix]); r.st = ST_OK; end
        end else if (it.tsel == TAB_GC) begin
          if (ix < GCBINS) begin r.rdata = DATA_W'(gc_hist[ix]); r.st = ST_OK; end
        end else if (it.tsel <= TAB_POS_N) begin
          if (ix < MAXLEN) begin
            r.st = ST_OK;
            if (it.tsel == TAB_POS_CNT) r.rdata = DATA_W'(pos_cnt[ix]);
            else if (it.tsel == TAB_POS_QSUM) r.rdata = DATA_W'(pos_qsum[ix]);
            else r.rdata = DATA_W'(pos_let[ix*NLET + (it.tsel - TAB_POS_A)]);
          end
        end else if (it.tsel == TAB_SCALAR) begin
          r.st = ST_OK;
          case (it.idx)
            SC_READ_COUNT: r.rdata = DATA_W'(n_reads);
            SC_SHORTEST:   r.rdata = DATA_W'(len_min);
            SC_LONGEST:    r.rdata = DATA_W'(len_max);
            SC_TOT_LEN:    r.rdata = DATA_W'(len_sum);
            SC_TOT_QUAL:   r.rdata = DATA_W'(qual_sum);
            SC_TOT_A, SC_TOT_C, SC_TOT_T, SC_TOT_G, SC_TOT_N:
              r.rdata = DATA_W'(let_sum[ix - SC_TOT_A]);
            default: r.st = ST_RANGE;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  function automatic stat_item_t random_item();
    stat_item_t it;
    logic [CHAR_W-1:0] letters [6];
    logic [127:0] rnd;
    int k;
    letters = '{CH_A, CH_C, CH_T, CH_G, CH_N, 8'h61};
    rnd = {$urandom, $urandom, $urandom, $urandom};
    it = rnd[$bits(stat_item_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 35) begin
      it.op = OP_SUMMARY;
      it.rlen = LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, MAXLEN));
      if ($urandom_range(0, 3) != 0) begin
        it.cc = BCNT_W'($urandom_range(0, it.rlen / 2));
        it.cg = BCNT_W'($urandom_range(0, it.rlen / 2));
      end
    end else if (k < 70) begin
      it.op = OP_BASE;
      it.idx = IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, 63));
      if ($urandom_range(0, 4) != 0) it.bchar = letters[$urandom_range(0, 5)];
    end else if (k < 97) begin
      it.op = OP_READOUT;
      it.tsel = TAB_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 10));
      if ($urandom_range(0, 9) != 0)
        it.idx = IDX_W'((it.tsel == TAB_SCALAR) ? $urandom_range(0, 10) :
                        (it.tsel == TAB_QUAL) ? $urandom_range(0, 255) :
                        (it.tsel == TAB_GC) ? $urandom_range(0, 100) : $urandom_range(0, 63));
    end else
      it.op = OP_NONE;
    return it;
  endfunction

  function automatic stat_item_t make_item(op_t op, logic [TAB_W-1:0] tsel,
                                           logic [IDX_W-1:0] idx);
    stat_item_t it;
    it = '0;
    it.op = op; it.tsel = tsel; it.idx = idx;
    return it;
  endfunction

  initial begin
    stat_item_t it;
    logic [CHAR_W-1:0] letters [6];
    letters = '{CH_A, CH_C, CH_T, CH_G, CH_N, 8'hFF};
    clear_stats();
    it = make_item(OP_SUMMARY, '0, '0); it.qavg = 16'hFFFF;
    it.ca = '1; it.cc = '1; it.ct = '1; it.cg = '1; it.cn = '1;
    pending_items.push_back(it);                       // zero length
    it.rlen = LEN_W'(MAXLEN); it.qavg = 16'h0080;      // gc clamp, round half up
    pending_items.push_back(it);
    it.rlen = 11'h7FF; it.qavg = 0; it.cc = 0; it.cg = 0;
    pending_items.push_back(it);                       // beyond length histogram
    foreach (letters[i]) begin
      it = make_item(OP_BASE, '0, (i == 5) ? 11'd0 : IDX_W'(MAXLEN - 1));
      it.bchar = letters[i]; it.bqual = 8'hFF;
      pending_items.push_back(it);
    end
    pending_items.push_back(make_item(OP_BASE, '0, IDX_W'(MAXLEN)));
    pending_items.push_back(make_item(OP_BASE, '0, 11'h7FF));
    for (int t = 0; t <= 15; t++)
      pending_items.push_back(make_item(OP_READOUT, TAB_W'(t),
                                        (t == TAB_SCALAR) ? 11'd9 : 11'd0));
    pending_items.push_back(make_item(OP_READOUT, TAB_POS_N, IDX_W'(MAXLEN - 1)));
    pending_items.push_back(make_item(OP_READOUT, TAB_LEN, IDX_W'(MAXLEN)));
    pending_items.push_back(make_item(OP_READOUT, TAB_LEN, IDX_W'(MAXLEN + 1)));
    pending_items.push_back(make_item(OP_READOUT, TAB_SCALAR, 11'd10));
    pending_items.push_back(make_item(OP_NONE, '1, '1));
    for (int n = 0; n < 1950; n++) pending_items.push_back(random_item());
    for (int s = 0; s <= 10; s++)
      pending_items.push_back(make_item(OP_READOUT, TAB_SCALAR, IDX_W'(s)));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk iff (in_tvalid && in_tready));
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    stim_done = 1;
    if (!failed && expected_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    stat_item_t nx;
    stat_result_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        nx = '0;
        nx.op = op_t'(in_tuser[1:0]); nx.tsel = in_tuser[5:2];
        nx.rlen = in_tdata[10:0]; nx.qavg = in_tdata[26:11];
        nx.ca = in_tdata[37:27]; nx.cc = in_tdata[48:38]; nx.ct = in_tdata[59:49];
        nx.cg = in_tdata[70:60]; nx.cn = in_tdata[81:71]; nx.bchar = in_tdata[89:82];
        nx.bqual = in_tdata[97:90]; nx.idx = in_tdata[108:98];
        accumulate_stats(nx, r);
        expected_results.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (pending_items.size() < QUIET_TAIL || $urandom_range(0, 7) != 0)) begin
          nx = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= {nx.tsel, nx.op};
          in_tdata <= {3'b0, nx.idx, nx.bqual, nx.bchar, nx.cn, nx.cg, nx.ct, nx.cc, nx.ca,
                       nx.qavg, nx.rlen};
        end else begin
          in_tvalid <= 1'b0;
          if (pending_items.size() > 0) in_gap = $urandom_range(0, 9);
        end
      end
    end
  end

  // monitor
  int out_stall = 0;
  always @(posedge clk) begin
    stat_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          failed = 1;
          $display("%0t: unexpected transaction data=%h status=%0d", $time, out_tdata,
                   out_tuser);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== want.rdata) begin
            failed = 1;
            $display("%0t: read_data expected %h actual %h", $time, want.rdata, out_tdata);
          end
          if (out_tuser !== want.st) begin
            failed = 1;
            $display("%0t: status expected %0d actual %0d", $time, want.st, out_tuser);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (pending_items.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else
        out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT && !stim_done) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
